/* rtl/core/ncl_pkg.sv */
// Shared types and constants for the nearest centerline frame block.
package ncl_pkg;

  // store geometry
  localparam int MAX_POINTS = 1024;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;

  // number formats
  localparam int COORD_W    = 32;
  localparam int UNIT_W     = 16;
  localparam int VEC_W      = COORD_W + 2;
  localparam int DIST_W     = 2 * COORD_W + 2;
  localparam int PT_W       = 3 * COORD_W;

  // normalizer widths: magnitudes are brought below 2^31 before squaring
  localparam int MAG_W      = 31;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int Q_W        = 31;
  localparam int ROOT_W     = 16;

  // item kinds
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // register map
  typedef enum logic [1:0] {
    REG_POINT_COUNT = 2'd0,
    REG_OFFSET_X    = 2'd1,
    REG_OFFSET_Y    = 2'd2,
    REG_OFFSET_Z    = 2'd3
  } reg_idx_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [UNIT_W-1:0]  unit_t;
  typedef logic signed [VEC_W-1:0]   vcomp_t;

  // one stored centerline point
  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } point_t;

  // queued work item; loads already carry the offset point
  typedef struct packed {
    logic              action;
    logic [IDX_W-1:0]  index;
    coord_t            x;
    coord_t            y;
    coord_t            z;
    logic [31:0]       tag;
  } item_t;

  // finished query result
  typedef struct packed {
    logic [31:0]      tag;
    logic [IDX_W-1:0] nearest;
    unit_t [2:0]      radial;
    unit_t [2:0]      axial;
    unit_t [2:0]      circ;
    logic             degenerate;
  } res_t;

endpackage

/* rtl/core/nearest_centerline_local_frame.sv */
// Top level of the nearest centerline point search with local frame.
//
// Usage: an item is transferred at a rising edge with start high and busy low.
// in_action selects a load (store in_coord_x/y/z plus the configured offset,
// saturated, at slot in_point_index) or a query (midpoint and in_query_tag).
// Items enter a two-entry queue; busy is high while that queue is full.
// Loads are written to the store by the back end and give no result. A query
// gives one result, shown for exactly one cycle with out_valid high; the
// receiver cannot stall it. Results leave in query order.
// The scan reads one store entry per cycle from the single read port into a
// pipe of distance, square and compare registers; then four normalizations run
// on one shared unit (31-step divide and 16-step square root per component),
// with two cross products between them. A zero-length vector ends its
// normalization early.
// With point_count below two a query skips the scan and is flagged
// degenerate. Registers are written through cfg_we/cfg_index/cfg_data; the
// user must do so only while the block is idle, the block does not enforce
// it. Reset clears the registers and the queue; store contents are undefined
// until loaded.
module nearest_centerline_local_frame (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_action,
  input  logic [ncl_pkg::IDX_W-1:0] in_point_index,
  input  logic signed [31:0]        in_coord_x,
  input  logic signed [31:0]        in_coord_y,
  input  logic signed [31:0]        in_coord_z,
  input  logic [31:0]               in_query_tag,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [31:0]               cfg_data,
  output logic                      out_valid,
  output logic [31:0]               out_result_tag,
  output logic [ncl_pkg::IDX_W-1:0] out_nearest_index,
  output logic signed [15:0]        out_radial_x,
  output logic signed [15:0]        out_radial_y,
  output logic signed [15:0]        out_radial_z,
  output logic signed [15:0]        out_axial_x,
  output logic signed [15:0]        out_axial_y,
  output logic signed [15:0]        out_axial_z,
  output logic signed [15:0]        out_circ_x,
  output logic signed [15:0]        out_circ_y,
  output logic signed [15:0]        out_circ_z,
  output logic                      out_degenerate
);

  logic [ncl_pkg::CNT_W-1:0] point_count;
  ncl_pkg::item_t            head;
  logic                      head_valid, pop;
  ncl_pkg::res_t             res;

  ncl_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_point_index (in_point_index),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_coord_z     (in_coord_z),
    .in_query_tag   (in_query_tag),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .point_count    (point_count),
    .head           (head),
    .head_valid     (head_valid),
    .pop            (pop)
  );

  ncl_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .point_count (point_count),
    .head        (head),
    .head_valid  (head_valid),
    .pop         (pop),
    .res         (res),
    .res_valid   (out_valid)
  );

  // unpack the result
  assign out_result_tag    = res.tag;
  assign out_nearest_index = res.nearest;
  assign out_radial_x      = res.radial[0];
  assign out_radial_y      = res.radial[1];
  assign out_radial_z      = res.radial[2];
  assign out_axial_x       = res.axial[0];
  assign out_axial_y       = res.axial[1];
  assign out_axial_z       = res.axial[2];
  assign out_circ_x        = res.circ[0];
  assign out_circ_y        = res.circ[1];
  assign out_circ_z        = res.circ[2];
  assign out_degenerate    = res.degenerate;

endmodule

/* rtl/core/ncl_ram.sv */
// Generic single write port, single read port RAM with registered read.
module ncl_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/ncl_front.sv */
// Front end: config registers, input transfer, offset add and a two-entry item queue.
module ncl_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_action,
  input  logic [ncl_pkg::IDX_W-1:0] in_point_index,
  input  ncl_pkg::coord_t           in_coord_x,
  input  ncl_pkg::coord_t           in_coord_y,
  input  ncl_pkg::coord_t           in_coord_z,
  input  logic [31:0]               in_query_tag,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [31:0]               cfg_data,
  output logic [ncl_pkg::CNT_W-1:0] point_count,
  output ncl_pkg::item_t            head,
  output logic                      head_valid,
  input  logic                      pop
);

  logic [ncl_pkg::CNT_W-1:0] point_count_r;
  ncl_pkg::coord_t           off_x_r, off_y_r, off_z_r;
  ncl_pkg::item_t            ent_r [2];
  logic                      wp_r, rp_r;
  logic [1:0]                cnt_r, cnt_nxt;
  logic                      acc;
  ncl_pkg::item_t            item;

  // add with saturation to the coordinate range
  function automatic ncl_pkg::coord_t sat_add(ncl_pkg::coord_t a, ncl_pkg::coord_t b);
    logic signed [ncl_pkg::COORD_W:0] s;
    s = {a[ncl_pkg::COORD_W-1], a} + {b[ncl_pkg::COORD_W-1], b};
    if (s[ncl_pkg::COORD_W] != s[ncl_pkg::COORD_W-1]) begin
      sat_add = s[ncl_pkg::COORD_W] ? {1'b1, {(ncl_pkg::COORD_W-1){1'b0}}}
                                    : {1'b0, {(ncl_pkg::COORD_W-1){1'b1}}};
    end else begin
      sat_add = s[ncl_pkg::COORD_W-1:0];
    end
  endfunction

  assign busy        = (cnt_r == 2'd2);
  assign acc         = start && !busy;
  assign head        = ent_r[rp_r];
  assign head_valid  = (cnt_r != 2'd0);
  assign point_count = point_count_r;

  // classify and shape the incoming item
  always_comb begin
    item.action = in_action;
    item.index  = in_point_index;
    item.tag    = in_query_tag;
    if (in_action == ncl_pkg::ACT_LOAD) begin
      item.x = sat_add(in_coord_x, off_x_r);
      item.y = sat_add(in_coord_y, off_y_r);
      item.z = sat_add(in_coord_z, off_z_r);
    end else begin
      item.x = in_coord_x;
      item.y = in_coord_y;
      item.z = in_coord_z;
    end
  end

  assign cnt_nxt = cnt_r + {1'b0, acc} - {1'b0, pop};

  // queue entries
  always_ff @(posedge clk) begin
    if (acc) begin
      ent_r[wp_r] <= item;
    end
  end

  // queue pointers and config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r          <= 1'b0;
      rp_r          <= 1'b0;
      cnt_r         <= 2'd0;
      point_count_r <= '0;
      off_x_r       <= '0;
      off_y_r       <= '0;
      off_z_r       <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (acc) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      if (cfg_we) begin
        case (ncl_pkg::reg_idx_t'(cfg_index))
          ncl_pkg::REG_POINT_COUNT: begin
            if (cfg_data[ncl_pkg::CNT_W-1:0] > ncl_pkg::CNT_W'(ncl_pkg::MAX_POINTS)) begin
              point_count_r <= ncl_pkg::CNT_W'(ncl_pkg::MAX_POINTS);
            end else begin
              point_count_r <= cfg_data[ncl_pkg::CNT_W-1:0];
            end
          end
          ncl_pkg::REG_OFFSET_X: off_x_r <= cfg_data;
          ncl_pkg::REG_OFFSET_Y: off_y_r <= cfg_data;
          ncl_pkg::REG_OFFSET_Z: off_z_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

/* rtl/core/ncl_norm.sv */
// Vector normalizer: bit-serial divide and square root per component, Q1.14 result.
module ncl_norm (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  ncl_pkg::vcomp_t vec [3],
  output logic            done,
  output logic            ok,
  output ncl_pkg::unit_t  u [3]
);

  typedef enum logic [5:0] {
    N_IDLE = 6'b000001,
    N_SQ   = 6'b000010,
    N_SUM  = 6'b000100,
    N_CHK  = 6'b001000,
    N_DIV  = 6'b010000,
    N_ROOT = 6'b100000
  } norm_state_t;

  norm_state_t                  state_r, state_nxt;
  logic [ncl_pkg::MAG_W-1:0]    m_r   [3];
  logic                         sgn_r [3];
  logic [ncl_pkg::SQ_W-1:0]     m2_r  [3];
  logic [ncl_pkg::SUM_W-1:0]    s_r, rem_r;
  logic [ncl_pkg::Q_W-1:0]      q_r;
  logic [ncl_pkg::ROOT_W-1:0]   root_r;
  logic [4:0]                   cnt_r;
  logic [1:0]                   comp_r;
  ncl_pkg::unit_t               u_r [3];
  logic                         ok_r, done_r;

  logic [ncl_pkg::VEC_W-1:0]    mag [3];
  logic [ncl_pkg::VEC_W-1:0]    top;
  logic [1:0]                   sh;
  logic [ncl_pkg::MAG_W-1:0]    msh [3];
  logic                         inbit;
  logic [ncl_pkg::SUM_W:0]      t, tdiff;
  logic                         ge;
  logic [ncl_pkg::ROOT_W-1:0]   try_v, root_new;
  logic [2*ncl_pkg::ROOT_W-1:0] try_sq;
  logic [ncl_pkg::ROOT_W:0]     kval;
  ncl_pkg::unit_t               kunit;

  assign done = done_r;
  assign ok   = ok_r;
  assign u    = u_r;

  // magnitudes, scaled down until every one is below 2^31
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mag[c] = vec[c][ncl_pkg::VEC_W-1] ? ncl_pkg::VEC_W'(-vec[c]) : ncl_pkg::VEC_W'(vec[c]);
    end
    top = mag[0] | mag[1] | mag[2];
    sh  = 2'd0;
    for (int b = ncl_pkg::MAG_W; b < ncl_pkg::VEC_W; b++) begin
      if (top[b]) begin
        sh = 2'(b - ncl_pkg::MAG_W + 1);
      end
    end
    for (int c = 0; c < 3; c++) begin
      msh[c] = ncl_pkg::MAG_W'(mag[c] >> sh);
    end
  end

  // restoring divide step: quotient of m^2 * 2^30 by the sum of squares
  always_comb begin
    inbit = (cnt_r == 5'd0) && m2_r[comp_r][0];
    t     = {rem_r, inbit};
    tdiff = t - {1'b0, s_r};
    ge    = (t >= {1'b0, s_r});
  end

  // square root step, then round to the unit value
  always_comb begin
    try_v    = root_r | (ncl_pkg::ROOT_W'(1) << cnt_r[3:0]);
    try_sq   = (2*ncl_pkg::ROOT_W)'(try_v) * (2*ncl_pkg::ROOT_W)'(try_v);
    root_new = (try_sq <= (2*ncl_pkg::ROOT_W)'(q_r)) ? try_v : root_r;
    kval     = ({1'b0, root_new} + (ncl_pkg::ROOT_W+1)'(1)) >> 1;
    kunit    = sgn_r[comp_r] ? ncl_pkg::UNIT_W'(-kval) : ncl_pkg::UNIT_W'(kval);
  end

  // sequencing
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      N_IDLE: if (start) state_nxt = N_SQ;
      N_SQ:   if (cnt_r == 5'd2) state_nxt = N_SUM;
      N_SUM:  state_nxt = N_CHK;
      N_CHK:  state_nxt = (s_r == '0) ? N_IDLE : N_DIV;
      N_DIV:  if (cnt_r == 5'(ncl_pkg::Q_W - 1)) state_nxt = N_ROOT;
      N_ROOT: if (cnt_r == 5'd0) state_nxt = (comp_r == 2'd2) ? N_IDLE : N_DIV;
      default: state_nxt = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      done_r  <= 1'b0;
      ok_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= 1'b0;
      case (state_r)
        N_IDLE: begin
          if (start) begin
            for (int c = 0; c < 3; c++) begin
              m_r[c]   <= msh[c];
              sgn_r[c] <= vec[c][ncl_pkg::VEC_W-1];
            end
            cnt_r <= 5'd0;
          end
        end
        N_SQ: begin
          m2_r[cnt_r[1:0]] <= ncl_pkg::SQ_W'(m_r[cnt_r[1:0]]) * ncl_pkg::SQ_W'(m_r[cnt_r[1:0]]);
          cnt_r <= cnt_r + 5'd1;
        end
        N_SUM: begin
          s_r <= ncl_pkg::SUM_W'(m2_r[0]) + ncl_pkg::SUM_W'(m2_r[1]) + ncl_pkg::SUM_W'(m2_r[2]);
        end
        N_CHK: begin
          if (s_r == '0) begin
            for (int c = 0; c < 3; c++) begin
              u_r[c] <= '0;
            end
            ok_r   <= 1'b0;
            done_r <= 1'b1;
          end else begin
            comp_r <= 2'd0;
            rem_r  <= ncl_pkg::SUM_W'(m2_r[0] >> 1);
            q_r    <= '0;
            cnt_r  <= 5'd0;
          end
        end
        N_DIV: begin
          rem_r <= ge ? tdiff[ncl_pkg::SUM_W-1:0] : t[ncl_pkg::SUM_W-1:0];
          q_r   <= {q_r[ncl_pkg::Q_W-2:0], ge};
          if (cnt_r == 5'(ncl_pkg::Q_W - 1)) begin
            cnt_r  <= 5'(ncl_pkg::ROOT_W - 1);
            root_r <= '0;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        N_ROOT: begin
          root_r <= root_new;
          if (cnt_r == 5'd0) begin
            u_r[comp_r] <= kunit;
            if (comp_r == 2'd2) begin
              ok_r   <= 1'b1;
              done_r <= 1'b1;
            end else begin
              comp_r <= comp_r + 2'd1;
              rem_r  <= ncl_pkg::SUM_W'(m2_r[comp_r + 2'd1] >> 1);
              q_r    <= '0;
            end
          end else begin
            cnt_r <= cnt_r - 5'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/ncl_back.sv */
// Back end: executes loads, scans the point store and builds the local frame.
module ncl_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [ncl_pkg::CNT_W-1:0] point_count,
  input  ncl_pkg::item_t            head,
  input  logic                      head_valid,
  output logic                      pop,
  output ncl_pkg::res_t             res,
  output logic                      res_valid
);

  typedef enum logic [11:0] {
    B_IDLE = 12'b000000000001,
    B_SCAN = 12'b000000000010,
    B_NRD  = 12'b000000000100,
    B_PRD  = 12'b000000001000,
    B_PWT  = 12'b000000010000,
    B_N0   = 12'b000000100000,
    B_N1   = 12'b000001000000,
    B_C1   = 12'b000010000000,
    B_N2   = 12'b000100000000,
    B_C2   = 12'b001000000000,
    B_N3   = 12'b010000000000,
    B_OUT  = 12'b100000000000
  } back_state_t;

  localparam int IW = ncl_pkg::IDX_W;
  localparam int CW = ncl_pkg::CNT_W;
  localparam int DW = ncl_pkg::COORD_W;

  back_state_t              state_r, state_nxt;

  // query context
  ncl_pkg::coord_t          qx_r, qy_r, qz_r;
  logic [31:0]              tag_r;
  logic [CW-1:0]            n_r;

  // scan pipeline
  logic [CW-1:0]            iss_r;
  logic                     v1_r, v2_r, v3_r;
  logic [IW-1:0]            idx1_r, idx2_r, idx3_r;
  logic [DW-1:0]            dm_r [3];
  logic [2*DW-1:0]          sq_r [3];
  logic [ncl_pkg::DIST_W-1:0] best_r, dsum;
  logic [IW-1:0]            near_r;

  // frame build
  ncl_pkg::point_t          pn_r, pp_r;
  ncl_pkg::unit_t           u0_r [3], u1_r [3], u2_r [3], u3_r [3];
  ncl_pkg::unit_t           ca [3], cb [3];
  logic                     ok_r;
  logic [1:0]               kc_r;
  logic [1:0]               i1, i2;
  logic signed [2*ncl_pkg::UNIT_W-1:0] p0_r, p1_r;
  ncl_pkg::vcomp_t          nvec_r [3];
  logic                     nstart_r;

  // store and normalizer
  logic                     ram_we;
  logic [IW-1:0]            ram_raddr;
  logic [ncl_pkg::PT_W-1:0] ram_rdata;
  ncl_pkg::point_t          rpt;
  logic                     ndone, nok;
  ncl_pkg::unit_t           nu [3];
  logic                     last;
  logic [IW-1:0]            partner;

  function automatic logic [DW-1:0] absdiff(ncl_pkg::coord_t a, ncl_pkg::coord_t b);
    logic signed [DW:0] d;
    d = {a[DW-1], a} - {b[DW-1], b};
    absdiff = d[DW] ? DW'(-d) : DW'(d);
  endfunction

  function automatic ncl_pkg::vcomp_t vsub(ncl_pkg::coord_t a, ncl_pkg::coord_t b);
    vsub = ncl_pkg::vcomp_t'(a) - ncl_pkg::vcomp_t'(b);
  endfunction

  assign rpt     = ncl_pkg::point_t'(ram_rdata);
  assign pop     = (state_r == B_IDLE) && head_valid;
  assign ram_we  = pop && (head.action == ncl_pkg::ACT_LOAD);
  assign last    = ({1'b0, near_r} == CW'(n_r - CW'(1)));
  assign partner = last ? IW'(near_r - IW'(1)) : IW'(near_r + IW'(1));

  always_comb begin
    case (state_r)
      B_NRD:   ram_raddr = near_r;
      B_PRD:   ram_raddr = partner;
      default: ram_raddr = iss_r[IW-1:0];
    endcase
  end

  ncl_ram #(
    .WIDTH (ncl_pkg::PT_W),
    .DEPTH (ncl_pkg::MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head.index),
    .wdata ({head.z, head.y, head.x}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ncl_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (nstart_r),
    .vec   (nvec_r),
    .done  (ndone),
    .ok    (nok),
    .u     (nu)
  );

  // distance of the oldest point in the scan pipe
  assign dsum = ncl_pkg::DIST_W'(sq_r[0]) + ncl_pkg::DIST_W'(sq_r[1])
              + ncl_pkg::DIST_W'(sq_r[2]);

  // cross product operands and rotating component indices
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ca[k] = (state_r == B_C1) ? u0_r[k] : u1_r[k];
      cb[k] = (state_r == B_C1) ? u1_r[k] : u2_r[k];
    end
    case (kc_r)
      2'd0:    begin i1 = 2'd1; i2 = 2'd2; end
      2'd1:    begin i1 = 2'd2; i2 = 2'd0; end
      default: begin i1 = 2'd0; i2 = 2'd1; end
    endcase
  end

  // sequencing
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (head_valid && head.action == ncl_pkg::ACT_QUERY) begin
          state_nxt = (point_count >= CW'(2)) ? B_SCAN : B_OUT;
        end
      end
      B_SCAN: if (iss_r == n_r && !v1_r && !v2_r && !v3_r) state_nxt = B_NRD;
      B_NRD:  state_nxt = B_PRD;
      B_PRD:  state_nxt = B_PWT;
      B_PWT:  state_nxt = B_N0;
      B_N0:   if (ndone) state_nxt = B_N1;
      B_N1:   if (ndone) state_nxt = B_C1;
      B_C1:   if (kc_r == 2'd3) state_nxt = B_N2;
      B_N2:   if (ndone) state_nxt = B_C2;
      B_C2:   if (kc_r == 2'd3) state_nxt = B_N3;
      B_N3:   if (ndone) state_nxt = B_OUT;
      B_OUT:  state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      nstart_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      v1_r     <= (state_r == B_SCAN) && (iss_r < n_r);
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      nstart_r <= (state_r == B_PWT)
               || (state_r == B_N0 && ndone)
               || ((state_r == B_C1 || state_r == B_C2) && kc_r == 2'd3);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    // query start
    if (pop && head.action == ncl_pkg::ACT_QUERY) begin
      qx_r   <= head.x;
      qy_r   <= head.y;
      qz_r   <= head.z;
      tag_r  <= head.tag;
      n_r    <= point_count;
      iss_r  <= '0;
      near_r <= '0;
      ok_r   <= (point_count >= CW'(2));
      for (int k = 0; k < 3; k++) begin
        u0_r[k] <= '0;
        u1_r[k] <= '0;
        u2_r[k] <= '0;
        u3_r[k] <= '0;
      end
    end

    // scan: issue, distance parts, squares, compare
    if (state_r == B_SCAN && iss_r < n_r) begin
      iss_r  <= iss_r + CW'(1);
      idx1_r <= iss_r[IW-1:0];
    end
    if (v1_r) begin
      dm_r[0] <= absdiff(qx_r, rpt.x);
      dm_r[1] <= absdiff(qy_r, rpt.y);
      dm_r[2] <= absdiff(qz_r, rpt.z);
      idx2_r  <= idx1_r;
    end
    if (v2_r) begin
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= (2*DW)'(dm_r[k]) * (2*DW)'(dm_r[k]);
      end
      idx3_r <= idx2_r;
    end
    if (v3_r && (idx3_r == '0 || dsum < best_r)) begin
      best_r <= dsum;
      near_r <= idx3_r;
    end

    // fetch nearest and partner points
    if (state_r == B_PRD) begin
      pn_r <= rpt;
    end
    if (state_r == B_PWT) begin
      pp_r      <= rpt;
      nvec_r[0] <= vsub(qx_r, pn_r.x);
      nvec_r[1] <= vsub(qy_r, pn_r.y);
      nvec_r[2] <= vsub(qz_r, pn_r.z);
    end

    // radial input done, start axial
    if (state_r == B_N0 && ndone) begin
      u0_r      <= nu;
      ok_r      <= ok_r && nok;
      nvec_r[0] <= vsub(pp_r.x, pn_r.x);
      nvec_r[1] <= vsub(pp_r.y, pn_r.y);
      nvec_r[2] <= vsub(pp_r.z, pn_r.z);
    end
    if (state_r == B_N1 && ndone) begin
      for (int k = 0; k < 3; k++) begin
        u1_r[k] <= last ? ncl_pkg::UNIT_W'(-nu[k]) : nu[k];
      end
      ok_r <= ok_r && nok;
      kc_r <= 2'd0;
    end

    // cross product, one component per cycle
    if (state_r == B_C1 || state_r == B_C2) begin
      if (kc_r != 2'd3) begin
        p0_r <= ca[i1] * cb[i2];
        p1_r <= ca[i2] * cb[i1];
      end
      if (kc_r != 2'd0) begin
        nvec_r[kc_r - 2'd1] <= ncl_pkg::vcomp_t'(p0_r) - ncl_pkg::vcomp_t'(p1_r);
      end
      kc_r <= kc_r + 2'd1;
    end

    if (state_r == B_N2 && ndone) begin
      u2_r <= nu;
      ok_r <= ok_r && nok;
      kc_r <= 2'd0;
    end
    if (state_r == B_N3 && ndone) begin
      u3_r <= nu;
      ok_r <= ok_r && nok;
    end
  end

  // result
  assign res_valid = (state_r == B_OUT);
  always_comb begin
    res.tag        = tag_r;
    res.nearest    = near_r;
    for (int k = 0; k < 3; k++) begin
      res.radial[k] = u3_r[k];
      res.axial[k]  = u1_r[k];
      res.circ[k]   = u2_r[k];
    end
    res.degenerate = !ok_r;
  end

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the nearest centerline point search with local frame.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ncl_pkg::*;

  localparam int WATCH_LIMIT = 20000;
  localparam int DRAIN_WAIT  = 16;
  localparam int RAND_ITEMS  = 525;

  typedef longint vec3_t [3];

  // one expected result
  typedef struct packed {
    logic [31:0]       tag;
    logic [IDX_W-1:0]  nearest;
    logic [15:0]       rad_x, rad_y, rad_z;
    logic [15:0]       ax_x, ax_y, ax_z;
    logic [15:0]       circ_x, circ_y, circ_z;
    logic              degenerate;
  } frame_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_ITEM} row_kind_e;

  // directed stimulus row; fixed expectation only where typed is set
  typedef struct {
    row_kind_e        kind;
    reg_idx_t         ridx;
    logic [31:0]      data;
    logic             act;
    logic [IDX_W-1:0] idx;
    logic [31:0]      x, y, z;
    logic [31:0]      tag;
    bit               typed;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_action = 1'b0;
  logic [IDX_W-1:0] in_point_index = '0;
  logic signed [31:0] in_coord_x = '0, in_coord_y = '0, in_coord_z = '0;
  logic [31:0] in_query_tag = '0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic out_valid;
  logic [31:0] out_result_tag;
  logic [IDX_W-1:0] out_nearest_index;
  logic signed [15:0] out_radial_x, out_radial_y, out_radial_z;
  logic signed [15:0] out_axial_x, out_axial_y, out_axial_z;
  logic signed [15:0] out_circ_x, out_circ_y, out_circ_z;
  logic out_degenerate;

  nearest_centerline_local_frame dut (.*);

  always #4 clk = ~clk;

  // predictor state
  longint pt_x [MAX_POINTS];
  longint pt_y [MAX_POINTS];
  longint pt_z [MAX_POINTS];
  int     live_count;
  longint shift_x, shift_y, shift_z;

  frame_t pending_frames [$];
  int mismatches, results_seen, queries_sent, loads_sent, idle_pct, rand_items, degen_seen;
  int watch_cnt;

  function automatic longint clamp_coord(longint v);
    if (v < -64'sd2147483648) return -64'sd2147483648;
    if (v > 64'sd2147483647) return 64'sd2147483647;
    return v;
  endfunction

  function automatic logic [63:0] mag(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // exact unit vector, Q1.14; returns 0 on zero length
  function automatic bit unit_vec(input vec3_t v, output vec3_t u);
    logic [63:0] m [3];
    logic [63:0] s, lo, hi, mid, t;
    logic [127:0] rhs, lhs;
    s = 0;
    for (int i = 0; i < 3; i++) m[i] = mag(v[i]);
    while ((m[0] | m[1] | m[2]) >= 64'h8000_0000)
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    for (int i = 0; i < 3; i++) s += m[i] * m[i];
    if (s == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return 1'b0;
    end
    for (int i = 0; i < 3; i++) begin
      rhs = {64'b0, m[i] * m[i]} << 30;
      lo = 0;
      hi = 64'd16384;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        t = 2 * mid - 1;
        lhs = {64'b0, t * t} * {64'b0, s};
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      u[i] = v[i] < 0 ? -longint'(lo) : longint'(lo);
    end
    return 1'b1;
  endfunction

  function automatic void cross3(input vec3_t a, input vec3_t b, output vec3_t c);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  // frame of one query against the current store
  function automatic frame_t predict_frame(logic [31:0] qx, qy, qz, logic [31:0] tag);
    frame_t f;
    longint mx, my, mz;
    logic [127:0] best, d;
    int near, partner;
    vec3_t a, rad, ax, cr, tmp;
    bit ok;
    mx = longint'($signed(qx));
    my = longint'($signed(qy));
    mz = longint'($signed(qz));
    f = '0;
    f.tag = tag;
    f.degenerate = 1'b1;
    if (live_count < 2) return f;
    best = '0;
    near = 0;
    for (int i = 0; i < live_count; i++) begin
      d = {64'b0, mag(mx - pt_x[i])} * {64'b0, mag(mx - pt_x[i])}
        + {64'b0, mag(my - pt_y[i])} * {64'b0, mag(my - pt_y[i])}
        + {64'b0, mag(mz - pt_z[i])} * {64'b0, mag(mz - pt_z[i])};
      if (i == 0 || d < best) begin
        best = d;
        near = i;
      end
    end
    partner = (near == live_count - 1) ? near - 1 : near + 1;
    a[0] = mx - pt_x[near];
    a[1] = my - pt_y[near];
    a[2] = mz - pt_z[near];
    ok = unit_vec(a, rad);
    a[0] = pt_x[partner] - pt_x[near];
    a[1] = pt_y[partner] - pt_y[near];
    a[2] = pt_z[partner] - pt_z[near];
    ok = unit_vec(a, ax) && ok;
    // last point pairs backward, axis flipped
    if (near == live_count - 1)
      for (int k = 0; k < 3; k++) ax[k] = -ax[k];
    cross3(rad, ax, tmp);
    ok = unit_vec(tmp, cr) && ok;
    cross3(ax, cr, tmp);
    ok = unit_vec(tmp, rad) && ok;
    f.nearest = near[IDX_W-1:0];
    f.rad_x = rad[0][15:0]; f.rad_y = rad[1][15:0]; f.rad_z = rad[2][15:0];
    f.ax_x = ax[0][15:0];   f.ax_y = ax[1][15:0];   f.ax_z = ax[2][15:0];
    f.circ_x = cr[0][15:0]; f.circ_y = cr[1][15:0]; f.circ_z = cr[2][15:0];
    f.degenerate = !ok;
    return f;
  endfunction

  // wait for all results, then let trailing loads drain
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, logic [31:0] d);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (r)
      REG_POINT_COUNT: live_count = (d[10:0] > MAX_POINTS) ? MAX_POINTS : int'(d[10:0]);
      REG_OFFSET_X:    shift_x = longint'($signed(d));
      REG_OFFSET_Y:    shift_y = longint'($signed(d));
      default:         shift_z = longint'($signed(d));
    endcase
  endtask

  // one item transfer; typed marks a fixed too-few-points expectation
  task automatic send_item(logic act, logic [IDX_W-1:0] idx, logic [31:0] x, y, z,
                           logic [31:0] tag, bit typed);
    frame_t f;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_point_index <= idx;
    in_coord_x <= x;
    in_coord_y <= y;
    in_coord_z <= z;
    in_query_tag <= tag;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (act == ACT_LOAD) begin
      pt_x[idx] = clamp_coord(longint'($signed(x)) + shift_x);
      pt_y[idx] = clamp_coord(longint'($signed(y)) + shift_y);
      pt_z[idx] = clamp_coord(longint'($signed(z)) + shift_z);
      loads_sent++;
    end else begin
      if (typed) begin
        f = '0;
        f.tag = tag;
        f.degenerate = 1'b1;
      end else begin
        f = predict_frame(x, y, z, tag);
      end
      pending_frames = {pending_frames, f};
      queries_sent++;
    end
  endtask

  // coordinate mix: clustered, full range, extremes
  function automatic logic [31:0] pick_coord(logic [31:0] base);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return base + $urandom_range(0, 2 << 20) - (1 << 20);
    if (sel < 80) return $urandom;
    if (sel < 85) return 32'h7fff_ffff;
    if (sel < 90) return 32'h8000_0000;
    return base;
  endfunction

  // result checker
  always @(posedge clk) begin
    frame_t got, want;
    if (rst_n && out_valid) begin
      got = {out_result_tag, out_nearest_index, out_radial_x, out_radial_y, out_radial_z,
             out_axial_x, out_axial_y, out_axial_z, out_circ_x, out_circ_y, out_circ_z,
             out_degenerate};
      results_seen++;
      if (got.degenerate) degen_seen++;
      if (pending_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer, tag %h", got.tag);
      end else begin
        want = pending_frames.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch tag exp %h got %h, near exp %0d got %0d, deg exp %b got %b",
                     want.tag, got.tag, want.nearest, got.nearest,
                     want.degenerate, got.degenerate);
            $display("  radial exp %h %h %h got %h %h %h", want.rad_x, want.rad_y,
                     want.rad_z, got.rad_x, got.rad_y, got.rad_z);
            $display("  axial  exp %h %h %h got %h %h %h", want.ax_x, want.ax_y,
                     want.ax_z, got.ax_x, got.ax_y, got.ax_z);
            $display("  circ   exp %h %h %h got %h %h %h", want.circ_x, want.circ_y,
                     want.circ_z, got.circ_x, got.circ_y, got.circ_z);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      watch_cnt <= 0;
    end else if (watch_cnt >= WATCH_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", watch_cnt);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      watch_cnt <= watch_cnt + 1;
    end
  end

  // directed rows
  row_t plan [$];

  function automatic void add_row(row_t w);
    plan = {plan, w};
  endfunction

  function automatic row_t cfg_row(reg_idx_t r, logic [31:0] d);
    row_t w;
    w.kind = ROW_CFG;
    w.ridx = r;
    w.data = d;
    w.act = ACT_LOAD;
    w.idx = '0;
    w.x = '0; w.y = '0; w.z = '0;
    w.tag = '0;
    w.typed = 1'b0;
    return w;
  endfunction

  function automatic row_t item_row(logic act, int idx, logic [31:0] x, y, z,
                                    logic [31:0] tag, bit typed);
    row_t w;
    w.kind = ROW_ITEM;
    w.ridx = REG_POINT_COUNT;
    w.data = '0;
    w.act = act;
    w.idx = idx[IDX_W-1:0];
    w.x = x; w.y = y; w.z = z;
    w.tag = tag;
    w.typed = typed;
    return w;
  endfunction

  initial begin
    int n, order [$], nq, phase;
    logic [31:0] bx, by, bz;
    mismatches = 0; results_seen = 0; queries_sent = 0; loads_sent = 0;
    degen_seen = 0; idle_pct = 0; rand_items = 0;
    live_count = 0; shift_x = 0; shift_y = 0; shift_z = 0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      pt_x[i] = 0; pt_y[i] = 0; pt_z[i] = 0;
    end

    // too few points, then a small store with extremes
    add_row(item_row(ACT_QUERY, 0, 32'h1234, 0, 0, 32'h0000_0000, 1));
    add_row(cfg_row(REG_POINT_COUNT, 32'd1));
    add_row(item_row(ACT_LOAD, 0, 0, 0, 0, 0, 0));
    add_row(item_row(ACT_QUERY, 0, 5, 6, 7, 32'hffff_ffff, 1));
    add_row(item_row(ACT_LOAD, 1, 32'h0001_0000, 0, 0, 0, 0));
    add_row(item_row(ACT_LOAD, 2, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0));
    add_row(item_row(ACT_LOAD, 3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0));
    add_row(cfg_row(REG_POINT_COUNT, 32'd4));
    // zero length radial: midpoint on a stored point
    add_row(item_row(ACT_QUERY, 0, 0, 0, 0, 32'h11, 0));
    // tie between slots 0 and 1 keeps slot 0
    add_row(item_row(ACT_QUERY, 0, 32'h8000, 32'h0001_0000, 0, 32'h22, 0));
    // nearest is last slot, partner backward
    add_row(item_row(ACT_QUERY, 0, 32'h8000_0000, 32'h8000_0010, 32'h8000_0000,
                     32'h33, 0));
    add_row(item_row(ACT_QUERY, 0, 32'h7fff_0000, 32'h7fff_ffff, 32'h0, 32'h44, 0));
    // parallel radial and axial on the x axis
    add_row(item_row(ACT_QUERY, 0, 32'hffff_0000, 0, 0, 32'h55, 0));
    // offsets at extremes saturate loaded points
    add_row(cfg_row(REG_OFFSET_X, 32'h7fff_ffff));
    add_row(cfg_row(REG_OFFSET_Y, 32'h8000_0000));
    add_row(cfg_row(REG_OFFSET_Z, 32'hffff_ffff));
    add_row(item_row(ACT_LOAD, 4, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 0, 0));
    add_row(item_row(ACT_LOAD, 5, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 0));
    add_row(cfg_row(REG_POINT_COUNT, 32'd6));
    add_row(item_row(ACT_QUERY, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'h66, 0));
    add_row(item_row(ACT_QUERY, 0, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h77, 0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(plan[i].ridx, plan[i].data);
      end else begin
        send_item(plan[i].act, plan[i].idx, plan[i].x, plan[i].y, plan[i].z,
                  plan[i].tag, plan[i].typed);
      end
    end

    // random phases: new settings, fresh small store, then mixed traffic
    phase = 0;
    while (rand_items < RAND_ITEMS) begin
      wait_drained();
      case (phase % 4)
        0: idle_pct = 0;
        1: idle_pct = 74;
        2: idle_pct = 21;
        default: idle_pct = 74;
      endcase
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12);
      write_reg(REG_OFFSET_X, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 20));
      write_reg(REG_OFFSET_Y, ($urandom_range(0, 3) == 0) ? $urandom : -$urandom_range(0, 1 << 20));
      write_reg(REG_OFFSET_Z, $urandom_range(0, 3) == 0 ? 32'h8000_0000 : $urandom_range(0, 9));
      write_reg(REG_POINT_COUNT, {21'($urandom_range(0, (1 << 21) - 1)), n[10:0]});
      bx = $urandom; by = $urandom; bz = $urandom;
      order.delete();
      for (int i = 0; i < n; i++) order = {order, i};
      order.shuffle();
      foreach (order[i]) begin
        send_item(ACT_LOAD, IDX_W'(order[i]), pick_coord(bx + order[i] * 32'h0004_0000),
                  pick_coord(by), pick_coord(bz), $urandom, 0);
        rand_items++;
      end
      nq = $urandom_range(4, 12);
      for (int q = 0; q < nq; q++) begin
        if ($urandom_range(0, 4) == 0) begin
          send_item(ACT_LOAD, IDX_W'($urandom_range(0, MAX_POINTS - 1)), pick_coord(bx),
                    pick_coord(by), pick_coord(bz), $urandom, 0);
          rand_items++;
        end
        send_item(ACT_QUERY, IDX_W'($urandom), pick_coord(bx), pick_coord(by),
                  pick_coord(bz), $urandom, 0);
        rand_items++;
      end
      phase++;
    end

    wait_drained();
    repeat (50) @(posedge clk);
    $display("Covered %0d loads and %0d queries over %0d random phases;", loads_sent,
             queries_sent, phase);
    $display("%0d results checked, %0d flagged degenerate, %0d mismatches", results_seen,
             degen_seen, mismatches);
    if (mismatches == 0 && pending_frames.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
